/* src/deq_pkg.sv */
// ---------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue core.
// ---------------------------------------------------------------------------
package deq_pkg;

  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_WORD_BITS = 32;
  localparam int VALUE_BITS    = 32;
  localparam int REQ_BITS      = 3;
  localparam int STATUS_BITS   = 2;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DUMP_FWD   = 3'd4,
    REQ_DUMP_BWD   = 3'd5
  } req_type_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_e;

  typedef enum logic [1:0] {
    OUT_OK,
    OUT_EMPTY,
    OUT_FULL,
    OUT_WORD
  } out_src_e;

  // controller -> datapath
  typedef struct packed {
    logic     push;
    logic     push_front;
    logic     pop;
    logic     pop_front;
    logic     rd_init;    // start a read sequence at offset zero
    logic     rd_dir;     // 1: walk from the back
    logic     rd_adv;     // step to the next offset
    logic     out_load;
    out_src_e out_src;
    logic     out_last;
  } deq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
    logic out_free;
  } deq_stat_t;

endpackage

/* src/deq_ctrl.sv */
// ---------------------------------------------------------------------------
// deq_ctrl
// Request decoder and sequencer for the double-ended queue.
// ---------------------------------------------------------------------------
module deq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [deq_pkg::REQ_BITS-1:0]  req_type_i,
  input  deq_pkg::deq_stat_t            stat_i,
  output deq_pkg::deq_cmd_t             cmd_o
);
  import deq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = !((state_q == S_IDLE) && stat_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_src = OUT_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_src = OUT_FULL;
              end else begin
                cmd_o.push       = 1'b1;
                cmd_o.push_front = (req_type_i == REQ_PUSH_FRONT);
                cmd_o.out_src    = OUT_OK;
              end
            end
            REQ_POP_FRONT, REQ_POP_BACK: begin
              if (stat_i.empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_last = 1'b1;
                cmd_o.out_src  = OUT_EMPTY;
              end else begin
                cmd_o.rd_init   = 1'b1;
                cmd_o.rd_dir    = (req_type_i == REQ_POP_BACK);
                cmd_o.pop       = 1'b1;
                cmd_o.pop_front = (req_type_i == REQ_POP_FRONT);
                state_d         = S_POP;
              end
            end
            REQ_DUMP_FWD, REQ_DUMP_BWD: begin
              if (stat_i.empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_last = 1'b1;
                cmd_o.out_src  = OUT_EMPTY;
              end else begin
                cmd_o.rd_init = 1'b1;
                cmd_o.rd_dir  = (req_type_i == REQ_DUMP_BWD);
                state_d       = S_DUMP;
              end
            end
            default: begin
              // unused request codes are dropped
            end
          endcase
        end
      end
      S_POP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = OUT_WORD;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = OUT_WORD;
          cmd_o.out_last = stat_i.dump_last;
          if (stat_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_adv = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* src/deq_datapath.sv */
// ---------------------------------------------------------------------------
// deq_datapath
// Ring store, front index, occupancy, read walker and result register.
// ---------------------------------------------------------------------------
module deq_datapath #(
  parameter int CAPACITY  = deq_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic signed [deq_pkg::VALUE_BITS-1:0]   value_i,
  input  deq_pkg::deq_cmd_t                       cmd_i,
  output deq_pkg::deq_stat_t                      stat_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [deq_pkg::STATUS_BITS-1:0]         status_o,
  output logic signed [deq_pkg::VALUE_BITS-1:0]   data_o,
  output logic                                    last_o
);
  import deq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW:0]   CAP_W  = (IW+1)'(CAPACITY);
  localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL_C = CW'(CAPACITY);

  logic [WORD_BITS-1:0] mem [CAPACITY];

  logic [IW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] walk_q, walk_d;
  logic          dir_q, dir_d;
  logic          rd_en;
  logic [IW:0]   rd_off;
  logic [IW-1:0] rd_pos, wr_pos, front_inc, front_dec;
  logic [WORD_BITS-1:0] rd_data_q, wr_word;
  logic signed [63:0]   val_ext, rd_ext;

  logic                   out_valid_q, out_valid_d;
  logic [STATUS_BITS-1:0] status_q;
  logic [VALUE_BITS-1:0]  data_q;
  logic                   last_q;

  // front + off, off below CAPACITY
  function automatic logic [IW-1:0] ring_add(logic [IW-1:0] base, logic [IW:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= CAP_W) begin
      sum = sum - CAP_W;
    end
    return sum[IW-1:0];
  endfunction

  assign front_inc = (front_q == LAST_I) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LAST_I : front_q - 1'b1;

  // read walker: offset from the front, or from the back when dir is set
  assign rd_en  = cmd_i.rd_init || cmd_i.rd_adv;
  assign walk_d = cmd_i.rd_init ? '0 : (cmd_i.rd_adv ? walk_q + 1'b1 : walk_q);
  assign dir_d  = cmd_i.rd_init ? cmd_i.rd_dir : dir_q;
  assign rd_off = dir_d ? ((IW+1)'(count_q) - 1'b1 - (IW+1)'(walk_d)) : (IW+1)'(walk_d);
  assign rd_pos = ring_add(front_q, rd_off);

  assign wr_pos  = cmd_i.push_front ? front_dec : ring_add(front_q, (IW+1)'(count_q));
  assign val_ext = 64'(value_i);
  assign wr_word = val_ext[WORD_BITS-1:0];
  assign rd_ext  = 64'($signed(rd_data_q));

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
      if (cmd_i.push_front) begin
        front_d = front_dec;
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
      if (cmd_i.pop_front) begin
        front_d = front_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      walk_q  <= '0;
      dir_q   <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      walk_q  <= walk_d;
      dir_q   <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_pos] <= wr_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_pos];
    end
  end

  // result register
  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q == FULL_C);
  assign stat_o.dump_last = (walk_q == count_q - 1'b1);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      last_q <= cmd_i.out_last;
      data_q <= '0;
      case (cmd_i.out_src)
        OUT_OK:    status_q <= STAT_OK;
        OUT_EMPTY: status_q <= STAT_EMPTY;
        OUT_FULL:  status_q <= STAT_FULL;
        OUT_WORD: begin
          status_q <= STAT_OK;
          data_q   <= rd_ext[VALUE_BITS-1:0];
        end
        default:   status_q <= STAT_OK;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_o      = $signed(data_q);
  assign last_o      = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_C)
    else $error("occupancy above capacity");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !stat_o.full)
    else $error("push issued on a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop || cmd_i.rd_init) |-> !stat_o.empty)
    else $error("read issued on an empty queue");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.out_load)
    else $error("stalled result overwritten");

endmodule

/* src/double_ended_queue_core.sv */
// ---------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue of signed words held in a ring store. Each
// request pushes at the front or back, pops from the front or back, or dumps
// the contents front to back or back to front; every defined request is answered by
// result items carrying status, data and a last flag (a dump gives one item
// per stored word, last on the final one). Pushes on a full queue are
// refused with status full, pops and dumps on an empty queue report empty,
// and unused request codes are dropped without a result. A push, or any
// request answered by a status alone, is taken and its result shows up the
// next cycle; a pop reads the ring store's one registered read port, then
// loads the result register; a dump passes one word per cycle through that
// read port while the result channel is not stalled. A new request is taken
// only while the core is idle and its result register is free or being
// drained. The store needs no clearing after reset: only written entries are ever read.
// ---------------------------------------------------------------------------
module double_ended_queue_core #(
  parameter int CAPACITY  = deq_pkg::DEF_CAPACITY,
  parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [deq_pkg::REQ_BITS-1:0]          req_type_i,
  input  logic signed [deq_pkg::VALUE_BITS-1:0] value_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [deq_pkg::STATUS_BITS-1:0]       status_o,
  output logic signed [deq_pkg::VALUE_BITS-1:0] data_o,
  output logic                                  last_o
);
  import deq_pkg::*;

  deq_cmd_t  cmd;   // sequencer commands
  deq_stat_t stat;  // queue and result-register status

  // decodes each request and walks pops and dumps through the read port
  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // ring store, pointers and the result register
  deq_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .data_o      (data_o),
    .last_o      (last_o)
  );

endmodule
